/* design/vfc_pkg.sv */
`default_nettype none
package vfc_pkg;

   localparam int GRID_DEFAULT = 16;
   localparam int COORD_W      = 4;
   localparam int MAT_W        = 8;
   localparam int VERT_W       = 5;
   localparam int FACES        = 6;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   localparam logic [2:0] FACE_FRONT  = 3'd0;
   localparam logic [2:0] FACE_BACK   = 3'd1;
   localparam logic [2:0] FACE_LEFT   = 3'd2;
   localparam logic [2:0] FACE_RIGHT  = 3'd3;
   localparam logic [2:0] FACE_TOP    = 3'd4;
   localparam logic [2:0] FACE_BOTTOM = 3'd5;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [4:0] vertex_x;
      logic [4:0] vertex_y;
      logic [4:0] vertex_z;
      logic [1:0] normal_x;
      logic [1:0] normal_y;
      logic [1:0] normal_z;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [2:0] face;
      logic       last;
   } vertex_type;

   // Neighbor step per face as 2-bit two's complement {dx, dy, dz}.
   function automatic logic [5:0] nbr_delta(input logic [2:0] face);
      logic [5:0] d;
      d = 6'b00_00_00;
      case (face)
         FACE_FRONT:  d = 6'b00_00_01;
         FACE_BACK:   d = 6'b00_00_11;
         FACE_LEFT:   d = 6'b11_00_00;
         FACE_RIGHT:  d = 6'b01_00_00;
         FACE_TOP:    d = 6'b00_01_00;
         FACE_BOTTOM: d = 6'b00_11_00;
         default:     d = 6'b00_00_00;
      endcase
      return d;
   endfunction

   // Face normal equals the neighbor step.
   function automatic logic [5:0] face_normal(input logic [2:0] face);
      return nbr_delta(face);
   endfunction

   // Corner offset {dx, dy, dz_back}: dz_back set means z - 1.
   function automatic logic [2:0] corner_ofs(input logic [2:0] face, input logic [1:0] corner);
      logic [11:0] row;
      row = 12'h000;
      case (face)
         FACE_FRONT:  row = {3'b010, 3'b110, 3'b100, 3'b000};
         FACE_BACK:   row = {3'b101, 3'b111, 3'b011, 3'b001};
         FACE_LEFT:   row = {3'b001, 3'b011, 3'b010, 3'b000};
         FACE_RIGHT:  row = {3'b110, 3'b111, 3'b101, 3'b100};
         FACE_TOP:    row = {3'b011, 3'b111, 3'b110, 3'b010};
         FACE_BOTTOM: row = {3'b100, 3'b101, 3'b001, 3'b000};
         default:     row = 12'h000;
      endcase
      return row[3*corner +: 3];
   endfunction

   // Color {red, green, blue} per material; unknown codes are black.
   function automatic logic [23:0] mat_color(input logic [7:0] code);
      logic [23:0] c;
      c = 24'h000000;
      case (code)
         8'd1:    c = {8'd13,  8'd128, 8'd13};
         8'd2:    c = {8'd191, 8'd64,  8'd13};
         8'd3:    c = {8'd77,  8'd102, 8'd255};
         default: c = 24'h000000;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

/* design/vfc_ram.sv */
`default_nettype none
module vfc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    addr,
   input  wire logic [WIDTH-1:0] wdata,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

/* design/vfc_vertex.sv */
`default_nettype none
module vfc_vertex (
   input  wire logic [3:0]        x,
   input  wire logic [3:0]        y,
   input  wire logic [3:0]        z,
   input  wire logic [2:0]        face,
   input  wire logic [1:0]        corner,
   input  wire logic [7:0]        code,
   input  wire logic [5:0]        exposed,
   output vfc_pkg::vertex_type    vert
);

   logic [2:0]  ofs;
   logic [5:0]  nrm;
   logic [23:0] color;
   logic [5:0]  later;

   always_comb begin
      ofs   = vfc_pkg::corner_ofs(face, corner);
      nrm   = vfc_pkg::face_normal(face);
      color = vfc_pkg::mat_color(code);
      later = exposed >> (face + 3'd1);

      vert.vertex_x = {1'b0, x} + {4'b0, ofs[2]};
      vert.vertex_y = {1'b0, y} + {4'b0, ofs[1]};
      vert.vertex_z = {1'b0, z} + {5{ofs[0]}};
      vert.normal_x = nrm[5:4];
      vert.normal_y = nrm[3:2];
      vert.normal_z = nrm[1:0];
      vert.red      = color[23:16];
      vert.green    = color[15:8];
      vert.blue     = color[7:0];
      vert.face     = face;
      // last vertex of the last exposed face closes the run
      vert.last     = (corner == 2'd3) && (later == 6'b0);
   end

endmodule
`default_nettype wire

/* design/voxel_face_culling_mesher.sv */
`default_nettype none
// Channel  Dir  Ports                       Content
// req      in   req_tvalid/tready/tdata/tuser  write or query of one voxel
// rsp      out  rsp_tvalid/tready/tdata/tuser/tlast  one quad corner per beat
//
// A write completes in its accept cycle. A query reads the voxel and its six neighbors
// in turn, then emits one vertex beat per corner of each exposed face, skipping hidden
// faces ahead of the last exposed one: at most 24 beats.
// After reset, sweep the voxel RAM to empty one entry a cycle with req_tready low
// (EX*EY*EZ entries, the axes clamped to 16 cells: 4096 for the default grid).
// A stalled rsp holds the vertex walk; the last beat may wait in rsp while the next req is taken.
module voxel_face_culling_mesher #(
   parameter int SIZE_X = vfc_pkg::GRID_DEFAULT,
   parameter int SIZE_Y = vfc_pkg::GRID_DEFAULT,
   parameter int SIZE_Z = vfc_pkg::GRID_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // voxel_x[3:0] voxel_y[7:4] voxel_z[11:8] material[19:12]
   input  wire logic [0:0]  req_tuser,   // mode[0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // vertex_x[4:0] vertex_y[9:5] vertex_z[14:10]
                                         // normal_x[16:15] normal_y[18:17] normal_z[20:19]
                                         // red[28:21] green[36:29] blue[44:37]
   output logic [2:0]       rsp_tuser,   // face[2:0]
   output logic             rsp_tlast
);

   // Coordinates are 4 bits wide, so only the first 16 cells of an axis are reachable.
   localparam int EX    = (SIZE_X < 16) ? SIZE_X : 16;
   localparam int EY    = (SIZE_Y < 16) ? SIZE_Y : 16;
   localparam int EZ    = (SIZE_Z < 16) ? SIZE_Z : 16;
   localparam int DEPTH = EX * EY * EZ;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [2:0] RD_LAST = 3'd7;

   vfc_pkg::state_type state_ff, state_in;

   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic [3:0]    x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [2:0]    rd_cnt_ff, rd_cnt_in;
   logic          slot_ing_ff, slot_ing_in;
   logic [7:0]    code_ff, code_in;
   logic [5:0]    exposed_ff, exposed_in;
   logic [2:0]    face_ff, face_in;
   logic [1:0]    corner_ff, corner_in;
   logic          rsp_valid_ff, rsp_valid_in;
   vfc_pkg::vertex_type rsp_vert_ff, rsp_vert_in;

   logic          ram_we;
   logic [AW-1:0] ram_addr;
   logic [7:0]    ram_wdata;
   logic [7:0]    ram_rdata;

   // request fields
   logic       req_mode;
   logic [3:0] req_x, req_y, req_z;
   logic [7:0] req_mat;
   logic       req_ing;
   logic       req_fire;
   logic [AW-1:0] req_addr;

   // neighbor slot addressing
   logic [5:0]    slot_delta;
   logic [4:0]    nx, ny, nz;
   logic [AW-1:0] slot_addr;

   logic       rsp_free;
   logic       load;
   vfc_pkg::vertex_type vert;

   assign req_mode = req_tuser[0];
   assign req_x    = req_tdata[3:0];
   assign req_y    = req_tdata[7:4];
   assign req_z    = req_tdata[11:8];
   assign req_mat  = req_tdata[19:12];
   assign req_ing  = ({1'b0, req_x} < 5'(EX)) && ({1'b0, req_y} < 5'(EY))
                     && ({1'b0, req_z} < 5'(EZ));
   assign req_fire = req_tvalid && req_tready;
   assign req_addr = AW'(int'(req_x) * EY * EZ + int'(req_y) * EZ + int'(req_z));

   // slot 0 is the voxel itself, slot k is the neighbor across face k-1
   always_comb begin
      slot_delta  = (rd_cnt_ff == 3'd0) ? 6'b0 : vfc_pkg::nbr_delta(rd_cnt_ff - 3'd1);
      nx          = {1'b0, x_ff} + {{3{slot_delta[5]}}, slot_delta[5:4]};
      ny          = {1'b0, y_ff} + {{3{slot_delta[3]}}, slot_delta[3:2]};
      nz          = {1'b0, z_ff} + {{3{slot_delta[1]}}, slot_delta[1:0]};
      slot_ing_in = (nx < 5'(EX)) && (ny < 5'(EY)) && (nz < 5'(EZ));
      slot_addr   = AW'(int'(nx[3:0]) * EY * EZ + int'(ny[3:0]) * EZ + int'(nz[3:0]));
   end

   vfc_ram #(
      .WIDTH (vfc_pkg::MAT_W),
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   vfc_vertex u_vertex (
      .x       (x_ff),
      .y       (y_ff),
      .z       (z_ff),
      .face    (face_ff),
      .corner  (corner_ff),
      .code    (code_ff),
      .exposed (exposed_ff),
      .vert    (vert)
   );

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // read results: code lands at count 1, face k's neighbor at count k+2
   always_comb begin
      exposed_in = exposed_ff;
      code_in    = code_ff;
      if (state_ff == vfc_pkg::ST_READ) begin
         if (rd_cnt_ff == 3'd1) begin
            code_in = ram_rdata;
         end
         if (rd_cnt_ff >= 3'd2) begin
            exposed_in[rd_cnt_ff - 3'd2] = !(slot_ing_ff && (ram_rdata != 8'd0));
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         vfc_pkg::ST_CLEAR: begin
            if (clr_addr_ff == AW'(DEPTH - 1)) state_in = vfc_pkg::ST_IDLE;
         end
         vfc_pkg::ST_IDLE: begin
            if (req_fire && req_ing && (req_mode == vfc_pkg::MODE_QUERY)) begin
               state_in = vfc_pkg::ST_READ;
            end
         end
         vfc_pkg::ST_READ: begin
            if (rd_cnt_ff == RD_LAST) begin
               if ((code_ff == 8'd0) || (exposed_in == 6'b0)) state_in = vfc_pkg::ST_IDLE;
               else                                         state_in = vfc_pkg::ST_EMIT;
            end
         end
         vfc_pkg::ST_EMIT: begin
            if (load && vert.last) state_in = vfc_pkg::ST_IDLE;
         end
         default: state_in = vfc_pkg::ST_CLEAR;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_tready   = 1'b0;
      ram_we       = 1'b0;
      ram_addr     = '0;
      ram_wdata    = 8'd0;
      load         = 1'b0;
      clr_addr_in  = clr_addr_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      rd_cnt_in    = rd_cnt_ff;
      face_in      = face_ff;
      corner_in    = corner_ff;
      unique case (state_ff)
         vfc_pkg::ST_CLEAR: begin
            ram_we      = 1'b1;
            ram_addr    = clr_addr_ff;
            clr_addr_in = clr_addr_ff + AW'(1);
         end
         vfc_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            ram_addr   = req_addr;
            ram_wdata  = req_mat;
            ram_we     = req_fire && req_ing && (req_mode == vfc_pkg::MODE_WRITE);
            x_in       = req_x;
            y_in       = req_y;
            z_in       = req_z;
            rd_cnt_in  = 3'd0;
            face_in    = vfc_pkg::FACE_FRONT;
            corner_in  = 2'd0;
         end
         vfc_pkg::ST_READ: begin
            ram_addr  = slot_addr;
            rd_cnt_in = rd_cnt_ff + 3'd1;
         end
         vfc_pkg::ST_EMIT: begin
            if (!exposed_ff[face_ff]) begin
               // hidden face: skip it
               face_in   = face_ff + 3'd1;
               corner_in = 2'd0;
            end else if (rsp_free) begin
               load      = 1'b1;
               corner_in = corner_ff + 2'd1;
               if (corner_ff == 2'd3) face_in = face_ff + 3'd1;
            end
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_vert_in  = rsp_vert_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_vert_in  = vert;
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vfc_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      y_ff        <= y_in;
      z_ff        <= z_in;
      rd_cnt_ff   <= rd_cnt_in;
      slot_ing_ff <= slot_ing_in;
      code_ff     <= code_in;
      exposed_ff  <= exposed_in;
      face_ff     <= face_in;
      corner_ff   <= corner_in;
      rsp_vert_ff <= rsp_vert_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_vert_ff.blue, rsp_vert_ff.green, rsp_vert_ff.red,
                        rsp_vert_ff.normal_z, rsp_vert_ff.normal_y, rsp_vert_ff.normal_x,
                        rsp_vert_ff.vertex_z, rsp_vert_ff.vertex_y, rsp_vert_ff.vertex_x};
   assign rsp_tuser  = rsp_vert_ff.face;
   assign rsp_tlast  = rsp_vert_ff.last;

endmodule
`default_nettype wire
